>>> rtl/core/hsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hsc_pkg;

  localparam int CordicSteps = 20;
  localparam int CordicW     = 36;

  typedef logic signed [CordicW-1:0] cw_t;

  localparam cw_t PiQ30     = 36'sd3373259426;
  localparam cw_t HalfPiQ30 = 36'sd1686629713;
  localparam cw_t KQ30      = 36'sd652032874;

  localparam logic [15:0] PiQ13    = 16'd25736;
  localparam int          AngShift = 17;

  typedef enum logic [2:0] {
    RegArenaSize   = 3'd0,
    RegWallMargin  = 3'd1,
    RegTurnGain    = 3'd2,
    RegCruiseSpeed = 3'd3,
    RegWideSpeed   = 3'd4,
    RegWallSlow    = 3'd5
  } reg_idx_e;

  function automatic cw_t atan_lut(input logic [4:0] idx);
    cw_t r;
    case (idx)
      5'd0:  r = 36'sd843314856;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043836;
      5'd3:  r = 36'sd133525158;
      5'd4:  r = 36'sd67021686;
      5'd5:  r = 36'sd33543515;
      5'd6:  r = 36'sd16775850;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194282;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/hsc_vec_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module hsc_vec_cordic (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  hsc_pkg::cw_t      x_i,
  input  hsc_pkg::cw_t      y_i,
  input  hsc_pkg::cw_t      z_i,
  output logic              valid_o,
  output hsc_pkg::cw_t      z_o
);
  import hsc_pkg::*;

  cw_t  x_q [1:CordicSteps];
  cw_t  y_q [1:CordicSteps];
  cw_t  z_q [1:CordicSteps];
  logic v_q [1:CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    cw_t  cx, cy, cz;
    logic cv;
    if (i == 0) begin : g_first
      assign cx = x_i;
      assign cy = y_i;
      assign cz = z_i;
      assign cv = valid_i;
    end else begin : g_next
      assign cx = x_q[i];
      assign cy = y_q[i];
      assign cz = z_q[i];
      assign cv = v_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy > 0) begin
          x_q[i+1] <= cx + (cy >>> i);
          y_q[i+1] <= cy - (cx >>> i);
          z_q[i+1] <= cz + atan_lut(5'(i));
        end else begin
          x_q[i+1] <= cx - (cy >>> i);
          y_q[i+1] <= cy + (cx >>> i);
          z_q[i+1] <= cz - atan_lut(5'(i));
        end
      end
    end
  end

  assign valid_o = v_q[CordicSteps];
  assign z_o     = z_q[CordicSteps];

endmodule
`default_nettype wire

>>> rtl/core/hsc_rot_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module hsc_rot_cordic (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  hsc_pkg::cw_t      a_i,
  output logic              valid_o,
  output hsc_pkg::cw_t      x_o
);
  import hsc_pkg::*;

  cw_t  x_q [1:CordicSteps];
  cw_t  y_q [1:CordicSteps];
  cw_t  a_q [1:CordicSteps];
  logic v_q [1:CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    cw_t  cx, cy, ca;
    logic cv;
    if (i == 0) begin : g_first
      assign cx = KQ30;
      assign cy = '0;
      assign ca = a_i;
      assign cv = valid_i;
    end else begin : g_next
      assign cx = x_q[i];
      assign cy = y_q[i];
      assign ca = a_q[i];
      assign cv = v_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ca[CordicW-1]) begin
          x_q[i+1] <= cx - (cy >>> i);
          y_q[i+1] <= cy + (cx >>> i);
          a_q[i+1] <= ca - atan_lut(5'(i));
        end else begin
          x_q[i+1] <= cx + (cy >>> i);
          y_q[i+1] <= cy - (cx >>> i);
          a_q[i+1] <= ca + atan_lut(5'(i));
        end
      end
    end
  end

  assign valid_o = v_q[CordicSteps];
  assign x_o     = x_q[CordicSteps];

endmodule
`default_nettype wire

>>> rtl/core/heading_steering_controller.sv
// Heading steering controller.
// Input beats on the s_axis group carry target point, robot position,
// heading and velocity; tlast marks the last task and enables the wall
// slowdown check. Each input beat yields exactly one output beat on the
// m_axis group with the turn rate and forward speed, in input order.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while no beat is in flight,
// as the block itself does not enforce this. Throughput: one beat per
// cycle while the output is not stalled. Pipeline: 49 register stages, the
// first loaded at the accepting edge: two 20-step CORDIC pipelines (bearing
// and cosine) plus 9 stages of input capture, pre-rotation, error wrap,
// gain, speed scaling, projection and output.
// Reset clears all valid bits and loads the default register values.
// The whole pipeline advances together: when the output holds a beat that
// is not taken, every stage holds and s_axis_tready_o drops; no beat is
// lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module heading_steering_controller (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // dest_x, dest_y, loc_x, loc_y, heading, vel_x, vel_y, zero pad
  input  wire  [111:0] s_axis_tdata_i,
  // last_task
  input  wire          s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // rotate_rate, forward_speed, zero pad
  output logic [31:0]  m_axis_tdata_o,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [15:0]  cfg_wdata_i
);
  import hsc_pkg::*;

  typedef struct packed {
    logic signed [24:0] pvx;
    logic signed [24:0] pvy;
    logic [15:0]        lx;
    logic [15:0]        ly;
    logic               vxn, vxp, vyn, vyp;
    logic signed [15:0] head;
    logic               zero;
    logic               last;
  } vside_t;

  typedef struct packed {
    logic signed [15:0] rot;
    logic               wide;
    logic               neg;
    logic               slow;
  } rside_t;

  logic [15:0] arena_q;
  logic [12:0] margin_q, cruise_q, wide_q;
  logic [5:0]  gain_q;
  logic [7:0]  wsf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q  <= 16'd51200;
      margin_q <= 13'd788;
      gain_q   <= 6'd15;
      cruise_q <= 13'd6144;
      wide_q   <= 13'd2048;
      wsf_q    <= 8'd77;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegArenaSize:   arena_q  <= cfg_wdata_i;
        RegWallMargin:  margin_q <= cfg_wdata_i[12:0];
        RegTurnGain:    gain_q   <= cfg_wdata_i[5:0];
        RegCruiseSpeed: cruise_q <= cfg_wdata_i[12:0];
        RegWideSpeed:   wide_q   <= cfg_wdata_i[12:0];
        RegWallSlow:    wsf_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic ov_q;
  assign en              = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: input register
  logic               v1_q;
  logic [15:0]        tx1_q, ty1_q, lx1_q, ly1_q;
  logic signed [15:0] hd1_q;
  logic signed [13:0] vx1_q, vy1_q;
  logic               last1_q;

  // stage 2: difference, pre-rotation, projection products
  logic   v2_q;
  cw_t    x2_q, y2_q, z2_q;
  vside_t s2_q;

  // stage A..D and tail
  logic               va_q, vb_q, vc_q, vd_q, vf_q, vg_q;
  logic signed [17:0] ang_q, px_q, py_q;
  logic signed [15:0] hda_q;
  logic               vxn_a_q, vxp_a_q, vyn_a_q, vyp_a_q, lasta_q;
  logic signed [18:0] err_b_q;
  logic               hit_b_q, last_b_q;
  logic [14:0]        mag_c_q;
  logic               pos_c_q, neg_c_q, slow_c_q;
  logic [20:0]        prod_d_q;
  logic               pos_d_q, neg_d_q, wide_d_q, flip_d_q, slow_d_q;
  cw_t                a_d_q;
  logic signed [46:0] prod_f_q;
  logic signed [15:0] rot_f_q, rot_g_q;
  logic               slow_f_q, slow_g_q;
  logic signed [13:0] spd_g_q;
  logic [31:0]        od_q;

  vside_t s1line_q [1:CordicSteps];
  rside_t s2line_q [1:CordicSteps];

  // stage 2 logic
  logic signed [16:0] dx, dy;
  cw_t                xs, ys;
  assign dx = $signed({1'b0, tx1_q}) - $signed({1'b0, lx1_q});
  assign dy = $signed({1'b0, ty1_q}) - $signed({1'b0, ly1_q});
  assign xs = cw_t'(dx) <<< 13;
  assign ys = cw_t'(dy) <<< 13;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx1_q   <= s_axis_tdata_i[15:0];
      ty1_q   <= s_axis_tdata_i[31:16];
      lx1_q   <= s_axis_tdata_i[47:32];
      ly1_q   <= s_axis_tdata_i[63:48];
      hd1_q   <= s_axis_tdata_i[79:64];
      vx1_q   <= s_axis_tdata_i[93:80];
      vy1_q   <= s_axis_tdata_i[107:94];
      last1_q <= s_axis_tlast_i;

      if (dx < 0) begin
        x2_q <= -xs;
        y2_q <= -ys;
        z2_q <= (dy >= 0) ? PiQ30 : -PiQ30;
      end else begin
        x2_q <= xs;
        y2_q <= ys;
        z2_q <= '0;
      end
      s2_q.pvx  <= 25'(vx1_q) * 25'sd1311;
      s2_q.pvy  <= 25'(vy1_q) * 25'sd1311;
      s2_q.lx   <= lx1_q;
      s2_q.ly   <= ly1_q;
      s2_q.vxn  <= vx1_q < 0;
      s2_q.vxp  <= vx1_q > 0;
      s2_q.vyn  <= vy1_q < 0;
      s2_q.vyp  <= vy1_q > 0;
      s2_q.head <= hd1_q;
      s2_q.zero <= (dx == 0) && (dy == 0);
      s2_q.last <= last1_q;

      s1line_q[1] <= s2_q;
      for (int k = 2; k <= CordicSteps; k++) begin
        s1line_q[k] <= s1line_q[k-1];
      end
    end
  end

  logic vcv;
  cw_t  zcv;
  hsc_vec_cordic u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .x_i     (x2_q),
    .y_i     (y2_q),
    .z_i     (z2_q),
    .valid_o (vcv),
    .z_o     (zcv)
  );

  vside_t sv;
  assign sv = s1line_q[CordicSteps];

  // stage B/C/D combinational
  logic signed [18:0] err_w, err_wb, err_c;
  logic signed [17:0] lo_t, hi_t;
  assign err_w  = 19'(ang_q) - 19'(hda_q);
  assign err_wb = (err_w > $signed({3'b0, PiQ13})) ?
                  err_w - $signed({2'b0, PiQ13, 1'b0}) : err_w;
  assign lo_t   = $signed({5'b0, margin_q});
  assign hi_t   = $signed({2'b0, arena_q}) - $signed({5'b0, margin_q});
  assign err_c  = (err_b_q < -$signed({3'b0, PiQ13})) ?
                  err_b_q + $signed({2'b0, PiQ13, 1'b0}) : err_b_q;

  cw_t a_raw;
  assign a_raw = $signed({4'b0, mag_c_q, 17'b0});

  logic [15:0]        rmag;
  rside_t             rs_in;
  assign rmag        = (prod_d_q > 21'(PiQ13)) ? PiQ13 : prod_d_q[15:0];
  assign rs_in.rot   = pos_d_q ? $signed(rmag) : (neg_d_q ? -$signed(rmag) : 16'sd0);
  assign rs_in.wide  = wide_d_q;
  assign rs_in.neg   = flip_d_q;
  assign rs_in.slow  = slow_d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q   <= sv.zero ? 18'sd0 : 18'((zcv + cw_t'(65536)) >>> AngShift);
      px_q    <= $signed({2'b0, sv.lx}) + 18'((sv.pvx + 25'sd32768) >>> 16);
      py_q    <= $signed({2'b0, sv.ly}) + 18'((sv.pvy + 25'sd32768) >>> 16);
      hda_q   <= sv.head;
      vxn_a_q <= sv.vxn;
      vxp_a_q <= sv.vxp;
      vyn_a_q <= sv.vyn;
      vyp_a_q <= sv.vyp;
      lasta_q <= sv.last;

      err_b_q  <= err_wb;
      hit_b_q  <= (px_q <= lo_t && vxn_a_q) || (px_q >= hi_t && vxp_a_q) ||
                  (py_q <= lo_t && vyn_a_q) || (py_q >= hi_t && vyp_a_q);
      last_b_q <= lasta_q;

      pos_c_q  <= err_c > 0;
      neg_c_q  <= err_c < 0;
      mag_c_q  <= err_c[18] ? 15'(-err_c) : 15'(err_c);
      slow_c_q <= hit_b_q && last_b_q;

      prod_d_q <= 21'(mag_c_q) * 21'(gain_q);
      wide_d_q <= {mag_c_q, 1'b0} > PiQ13;
      flip_d_q <= a_raw > HalfPiQ30;
      a_d_q    <= (a_raw > HalfPiQ30) ? PiQ30 - a_raw : a_raw;
      pos_d_q  <= pos_c_q;
      neg_d_q  <= neg_c_q;
      slow_d_q <= slow_c_q;

      s2line_q[1] <= rs_in;
      for (int k = 2; k <= CordicSteps; k++) begin
        s2line_q[k] <= s2line_q[k-1];
      end
    end
  end

  logic vrc;
  cw_t  xrc;
  hsc_rot_cordic u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .a_i     (a_d_q),
    .valid_o (vrc),
    .x_o     (xrc)
  );

  rside_t rv;
  cw_t    cosv;
  logic signed [32:0] cos33;
  logic signed [13:0] scale;
  assign rv    = s2line_q[CordicSteps];
  assign cosv  = rv.neg ? -xrc : xrc;
  assign cos33 = 33'(cosv);
  assign scale = $signed({1'b0, (rv.wide ? wide_q : cruise_q)});

  logic signed [16:0] spd_w;
  assign spd_w = 17'((prod_f_q + 47'sd536870912) >>> 30);

  logic [20:0] slowed;
  assign slowed = 21'(spd_g_q[12:0]) * 21'(wsf_q) + 21'd128;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_f_q <= 47'(scale) * 47'(cos33);
      rot_f_q  <= rv.rot;
      slow_f_q <= rv.slow;

      if (spd_w > 17'sd8191) begin
        spd_g_q <= 14'sd8191;
      end else if (spd_w < -17'sd8191) begin
        spd_g_q <= -14'sd8191;
      end else begin
        spd_g_q <= 14'(spd_w);
      end
      rot_g_q  <= rot_f_q;
      slow_g_q <= slow_f_q;

      od_q[15:0]  <= rot_g_q;
      od_q[29:16] <= (slow_g_q && spd_g_q > 0) ? 14'(slowed >> 8) : spd_g_q;
      od_q[31:30] <= 2'b00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      va_q <= vcv;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      vf_q <= vrc;
      vg_q <= vf_q;
      ov_q <= vg_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import hsc_pkg::*;

  localparam logic [2:0] RegUnused = 3'd6;
  localparam int WatchLimit = 5000;

  typedef struct {
    logic [15:0]        dest_x, dest_y, loc_x, loc_y;
    logic signed [15:0] heading;
    logic signed [13:0] vel_x, vel_y;
    logic               last_task;
  } pose_t;

  typedef struct {
    logic [15:0] rot;
    logic [13:0] spd;
  } cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = '0;
  logic [15:0]  cfg_wdata = '0;

  heading_steering_controller uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  longint arena = 51200, margin = 788, gain = 15, cruise = 6144, wide = 2048, slow = 77;

  pose_t  pend_poses[$];
  pose_t  pose_q[$];
  cmd_t   cmd_q[$];
  int     errors = 0, n_in = 0, n_out = 0, n_wall = 0, cyc = 0, quiet = 0, phase = 0;
  int     rx_hold = 0;
  bit     hold_done = 0;
  bit     s_fire = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint cordic_bearing(longint dx, longint dy);
    longint x, y, z, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 8192;
    y = dy * 8192;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PiQ30) : -longint'(PiQ30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_lut(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_lut(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint cordic_cos(longint a);
    longint x, y, xs, ys;
    bit neg;
    x = longint'(KQ30);
    y = 0;
    neg = 0;
    if (a > longint'(HalfPiQ30)) begin
      a = longint'(PiQ30) - a;
      neg = 1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= longint'(atan_lut(5'(i)));
      end else begin
        x += ys; y -= xs; a += longint'(atan_lut(5'(i)));
      end
    end
    return neg ? -x : x;
  endfunction

  function automatic cmd_t steer(pose_t p);
    longint half, pi_a, ang, err, sgn, mag, rot, scale, speed, px, py, hi;
    longint vx, vy;
    bit hx, hy;
    cmd_t c;
    half = longint'(1) << (AngShift - 1);
    pi_a = (longint'(PiQ30) + half) >>> AngShift;
    ang = (cordic_bearing(longint'(p.dest_x) - longint'(p.loc_x),
                          longint'(p.dest_y) - longint'(p.loc_y)) + half) >>> AngShift;
    err = ang - longint'(p.heading);
    if (err > pi_a) err -= 2 * pi_a;
    if (err < -pi_a) err += 2 * pi_a;
    sgn = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
    mag = sgn * err;
    rot = (mag * gain > pi_a) ? sgn * pi_a : sgn * gain * mag;
    scale = (mag * 2 > pi_a) ? wide : cruise;
    speed = (scale * cordic_cos(mag << AngShift) + (longint'(1) << 29)) >>> 30;
    if (speed > 8191) speed = 8191;
    if (speed < -8191) speed = -8191;
    if (p.last_task) begin
      vx = longint'(p.vel_x);
      vy = longint'(p.vel_y);
      px = longint'(p.loc_x) + ((vx * 1311 + 32768) >>> 16);
      py = longint'(p.loc_y) + ((vy * 1311 + 32768) >>> 16);
      hi = arena - margin;
      hx = (px <= margin && vx < 0) || (px >= hi && vx > 0);
      hy = (py <= margin && vy < 0) || (py >= hi && vy > 0);
      if ((hx || hy) && speed > 0) begin
        speed = (speed * slow + 128) >>> 8;
        n_wall++;
      end
    end
    c.rot = rot[15:0];
    c.spd = speed[13:0];
    return c;
  endfunction

  function automatic logic [111:0] pack_pose(pose_t p);
    return {4'b0, p.vel_y, p.vel_x, p.heading, p.loc_y, p.loc_x, p.dest_y, p.dest_x};
  endfunction

  function automatic logic [15:0] near_edge();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) return 16'($urandom_range(0, 2000));
    if (k == 1) return 16'(65535 - $urandom_range(0, 2000));
    if (k == 2) return 16'(arena - margin + $urandom_range(0, 800) - 400);
    return 16'($urandom);
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int k;
    k = $urandom_range(0, 99);
    p.dest_x = 16'($urandom);
    p.dest_y = 16'($urandom);
    p.heading = 16'($urandom_range(0, 51472) - 25736);
    p.vel_x = 14'($urandom);
    p.vel_y = 14'($urandom);
    p.last_task = 1'($urandom_range(0, 1));
    if (k < 35) begin
      p.loc_x = near_edge();
      p.loc_y = near_edge();
      p.last_task = 1'b1;
    end else begin
      p.loc_x = 16'($urandom);
      p.loc_y = 16'($urandom);
    end
    if (k < 8) begin
      p.dest_x = p.loc_x;
      p.dest_y = p.loc_y;
    end else if (k < 14) begin
      p.dest_x = p.loc_x + 16'($urandom_range(0, 4));
      p.dest_y = p.loc_y - 16'($urandom_range(0, 4));
    end
    return p;
  endfunction

  function automatic pose_t mk(int dx, int dy, int lx, int ly, int hd, int vx, int vy, bit lt);
    pose_t p;
    p.dest_x = 16'(dx); p.dest_y = 16'(dy); p.loc_x = 16'(lx); p.loc_y = 16'(ly);
    p.heading = 16'(hd); p.vel_x = 14'(vx); p.vel_y = 14'(vy); p.last_task = lt;
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch beat %0d %s: got %0h want %0h", n_out, what, got, want);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 16'(val);
    case (idx)
      RegArenaSize:   arena = longint'(val) & 64'hFFFF;
      RegWallMargin:  margin = longint'(val) & 64'h1FFF;
      RegTurnGain:    gain = longint'(val) & 64'h3F;
      RegCruiseSpeed: cruise = longint'(val) & 64'h1FFF;
      RegWideSpeed:   wide = longint'(val) & 64'h1FFF;
      RegWallSlow:    slow = longint'(val) & 64'hFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int a, int m, int g, int c, int w, int s);
    write_reg(RegArenaSize, a);
    write_reg(RegWallMargin, m);
    write_reg(RegTurnGain, g);
    write_reg(RegCruiseSpeed, c);
    write_reg(RegWideSpeed, w);
    write_reg(RegWallSlow, s);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pend_poses.size() != 0 || s_tvalid || cmd_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    phase++;
    for (int i = 0; i < n; i++) pend_poses.push_back(rand_pose());
    drain();
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || s_fire)) begin
      if (pend_poses.size() != 0 &&
          !(phase != 4 && $urandom_range(0, 99) < 13)) begin
        s_tdata <= pack_pose(pend_poses[0]);
        s_tlast <= pend_poses[0].last_task;
        pose_q.push_back(pend_poses.pop_front());
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (phase == 2 && !hold_done && rx_hold == 0) begin
      rx_hold = 300;
      hold_done = 1;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (phase == 4) || ($urandom_range(0, 99) >= 13);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cmd_t want;
    cyc++;
    s_fire = s_tvalid && s_tready;
    if (s_fire) begin
      cmd_q.push_back(steer(pose_q.pop_front()));
      n_in++;
    end
    if (m_tvalid && m_tready) begin
      if (cmd_q.size() == 0) begin
        report("unexpected beat", m_tdata, '0);
      end else begin
        want = cmd_q.pop_front();
        if (m_tdata[15:0] !== want.rot)
          report("rotate_rate", 32'(m_tdata[15:0]), 32'(want.rot));
        if (m_tdata[29:16] !== want.spd)
          report("forward_speed", 32'(m_tdata[29:16]), 32'(want.spd));
      end
      n_out++;
    end
    quiet = (s_fire || (m_tvalid && m_tready)) ? 0 : quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pend_poses.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pend_poses.push_back(mk(65535, 65535, 0, 0, 25736, 8191, 8191, 1));
    pend_poses.push_back(mk(0, 0, 65535, 65535, -25736, -8192, -8192, 1));
    pend_poses.push_back(mk(40000, 1000, 1000, 1000, 0, 0, 0, 0));
    pend_poses.push_back(mk(1000, 1000, 40000, 1000, 25736, 0, 0, 0));
    pend_poses.push_back(mk(1000, 1000, 40000, 1000, -25736, 0, 0, 0));
    pend_poses.push_back(mk(5000, 9000, 5000, 1000, 0, 0, 0, 0));
    pend_poses.push_back(mk(5000, 100, 5000, 9000, 20000, 0, 0, 0));
    pend_poses.push_back(mk(30000, 30000, 30000, 30000, 12345, 3000, -3000, 1));
    pend_poses.push_back(mk(20000, 20000, 500, 500, 6434, -8192, -8192, 1));
    pend_poses.push_back(mk(20000, 20000, 51000, 51000, 6434, 8191, 8191, 1));
    pend_poses.push_back(mk(20000, 20000, 51000, 500, -25736, 8191, -1, 1));
    pend_poses.push_back(mk(20000, 20000, 500, 51000, 25736, 1, 8191, 1));
    pend_poses.push_back(mk(20000, 20000, 500, 51000, 25736, 1, 8191, 0));
    pend_poses.push_back(mk(0, 65535, 65535, 0, 0, 0, 0, 0));
    pend_poses.push_back(mk(65535, 0, 0, 65535, -1, -1, 1, 1));
    pend_poses.push_back(mk(100, 100, 0, 0, 12868, 0, 0, 0));
    pend_poses.push_back(mk(100, 101, 0, 0, 12869, 0, 0, 0));
    pend_poses.push_back(mk(0, 100, 100, 0, -25000, 0, 0, 0));
    pend_poses.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1));
    pend_poses.push_back(mk(100, 0, 0, 0, 32767, 0, 0, 0));
    pend_poses.push_back(mk(0, 100, 0, 0, -32768, 0, 0, 1));
    drain();
    run_random(120);
    set_all(1, 8191, 63, 8191, 8191, 255);
    write_reg(RegUnused, 16'h1234);
    run_random(120);
    set_all(65535, 0, 1, 0, 0, 0);
    run_random(120);
    set_all($urandom_range(20000, 65535), $urandom_range(0, 8191), $urandom_range(1, 63),
            $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 255));
    run_random(120);
    set_all(51200, 788, 15, 6144, 2048, 77);
    run_random(120);
    repeat (60) @(negedge clk_i);
    $display("%0d robot updates in, %0d commands out, %0d wall slowdowns", n_in, n_out, n_wall);
    $display("four register sets, an unused index write, a long output stall");
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hsc_pkg.sv
rtl/core/hsc_vec_cordic.sv
rtl/core/hsc_rot_cordic.sv
rtl/core/heading_steering_controller.sv
bench/tb.sv
